FILE: hw/rtl/stc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the seconds-to-calendar converter
// Reciprocal constants for the divisions by 15, 3, 7 and 1461, the day
// count split record passed between the two pipeline halves and the
// cumulative month start table.
// ----------------------------------------------------------------------------
package stc_pkg;

    // floor(x / 15) = (x * RECIP_15_A) >> 34 for any 30-bit x
    localparam logic [30:0] RECIP_15_A   = 31'd1145324613;
    localparam int          SHIFT_15_A   = 34;
    // floor(x / 15) = (x * RECIP_15_B) >> 29 for any 25-bit x
    localparam logic [25:0] RECIP_15_B   = 26'd35791395;
    localparam int          SHIFT_15_B   = 29;
    // floor(x / 3) = (x * RECIP_3) >> 19 for any 18-bit x
    localparam logic [17:0] RECIP_3      = 18'd174763;
    localparam int          SHIFT_3      = 19;
    // floor(x / 1461) = (x * RECIP_1461) >> 27 for any 16-bit x
    localparam logic [16:0] RECIP_1461   = 17'd91868;
    localparam int          SHIFT_1461   = 27;
    // floor(x / 7) = (x * RECIP_7) >> 20 for any 17-bit x
    localparam logic [17:0] RECIP_7      = 18'd149797;
    localparam int          SHIFT_7      = 20;

    // calendar constants; 1904-01-01 was a Friday and opens a leap year
    localparam logic [10:0] YEAR_BASE    = 11'd1904;
    localparam logic [15:0] DAYS_PER_4Y  = 16'd1461;
    localparam logic [2:0]  WEEKDAY_BASE = 3'd5;

    // time of day split off, day count since the epoch still whole
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [20:0] hours;
        logic [15:0] days;
    } stc_time_t;

    // first day of each year inside a four-year cycle, the first year leap
    function automatic logic [10:0] year_start(input logic [1:0] idx);
        logic [10:0] start;
        case (idx)
            2'd0:    start = 11'd0;
            2'd1:    start = 11'd366;
            2'd2:    start = 11'd731;
            2'd3:    start = 11'd1096;
            default: start = 11'd0;
        endcase
        return start;
    endfunction

    // cumulative days before month idx, one more from March on in a leap year
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] start;
        case (idx)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd59;
            4'd3:    start = 9'd90;
            4'd4:    start = 9'd120;
            4'd5:    start = 9'd151;
            4'd6:    start = 9'd181;
            4'd7:    start = 9'd212;
            4'd8:    start = 9'd243;
            4'd9:    start = 9'd273;
            4'd10:   start = 9'd304;
            4'd11:   start = 9'd334;
            4'd12:   start = 9'd365;
            default: start = 9'd0;
        endcase
        if (leap && (idx >= 4'd2))
        begin
            start = start + 9'd1;
        end
        return start;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/stc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_in_if: timestamp channel
// Valid/ready channel that carries one seconds count per transfer.
// ----------------------------------------------------------------------------
interface stc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_count;

    modport source (output valid, output seconds_count, input ready);
    modport sink   (input valid, input seconds_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/stc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_out_if: calendar date channel
// Valid/ready channel that carries one broken-down date and time per transfer.
// ----------------------------------------------------------------------------
interface stc_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [10:0] year;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;

    modport source (output valid, output second, output minute, output hour,
                    output day_of_month, output month_index, output year,
                    output weekday, output day_of_year, input ready);
    modport sink   (input valid, input second, input minute, input hour,
                    input day_of_month, input month_index, input year,
                    input weekday, input day_of_year, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/seconds_to_calendar_date_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_top: seconds count to calendar date converter
// Converts seconds since 1904-01-01 00:00:00 into second, minute, hour,
// day of month, month, year, weekday and day of year.
//
//   channel    | role | payload
//   -----------+------+---------------------------------------------------
//   timestamp  | in   | seconds_count[31:0]
//   date       | out  | second, minute, hour, day_of_month, month_index,
//              |      | year, weekday, day_of_year
//
// Six register stages, at most two reciprocal multipliers in a stage; one
// transfer per cycle is sustained while the output is ready. The last stage
// is the output register. Valid bits reset asynchronously, payload is not
// reset. A stalled output fills the stages behind it one by one; each stage
// loads when empty or when it drains, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_top import stc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    stc_in_if.sink    timestamp,
    stc_out_if.source date
);

    logic      time_valid;
    logic      time_ready;
    stc_time_t time_data;

    // time-of-day split
    stc_time_split u_time_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .timestamp  (timestamp),
        .time_valid (time_valid),
        .time_ready (time_ready),
        .time_data  (time_data)
    );

    // calendar split
    stc_date_split u_date_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .time_valid (time_valid),
        .time_ready (time_ready),
        .time_data  (time_data),
        .date       (date)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/stc_time_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_time_split: first three pipeline stages
// Splits the seconds count by 60, 60 and 24 with reciprocal multipliers,
// one reciprocal multiplier per stage, and hands on second, minute, total
// hours and the day count.
// ----------------------------------------------------------------------------
module stc_time_split import stc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    stc_in_if.sink    timestamp,
    output logic      time_valid,
    input  logic      time_ready,
    output stc_time_t time_data
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        en1, en2, en3;

    logic [31:0] s1_count_reg;
    logic [26:0] s1_q1_reg;
    logic [60:0] prod1;
    logic [26:0] q1_next;

    logic [5:0]  s2_sec_reg;
    logic [26:0] s2_q1_reg;
    logic [20:0] s2_q2_reg;
    logic [31:0] q1_x60;
    logic [31:0] sec_full;
    logic [50:0] prod2;
    logic [20:0] q2_next;

    stc_time_t   s3_reg;
    logic [26:0] q2_x60;
    logic [26:0] min_full;
    logic [36:0] prod3;
    logic [15:0] days_next;

    // stage enables, a stage loads when empty or when its contents move on
    assign en3 = !v3_reg || time_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign timestamp.ready = en1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= timestamp.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 1: total minutes = seconds / 60 = (seconds / 4) / 15
    assign prod1   = 61'(timestamp.seconds_count[31:2]) * 61'(RECIP_15_A);
    assign q1_next = prod1[SHIFT_15_A +: 27];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_count_reg <= timestamp.seconds_count;
            s1_q1_reg    <= q1_next;
        end
    end

    // stage 2: second remainder, total hours = minutes / 60
    assign q1_x60   = 32'(s1_q1_reg) * 32'd60;
    assign sec_full = s1_count_reg - q1_x60;
    assign prod2    = 51'(s1_q1_reg[26:2]) * 51'(RECIP_15_B);
    assign q2_next  = prod2[SHIFT_15_B +: 21];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_sec_reg <= sec_full[5:0];
            s2_q1_reg  <= s1_q1_reg;
            s2_q2_reg  <= q2_next;
        end
    end

    // stage 3: minute remainder, days = hours / 24 = (hours / 8) / 3
    assign q2_x60    = 27'(s2_q2_reg) * 27'd60;
    assign min_full  = s2_q1_reg - q2_x60;
    assign prod3     = 37'(s2_q2_reg[20:3]) * 37'(RECIP_3);
    assign days_next = prod3[SHIFT_3 +: 16];

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_reg.second <= s2_sec_reg;
            s3_reg.minute <= min_full[5:0];
            s3_reg.hours  <= s2_q2_reg;
            s3_reg.days   <= days_next;
        end
    end

    assign time_valid = v3_reg;
    assign time_data  = s3_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/stc_date_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_date_split: last three pipeline stages
// Takes the day count apart into four-year cycles, years and months and
// works out hour and weekday; the last stage is the output register.
// Between 1904 and 2040 every fourth year is leap (2000 included), so the
// four-year cycle alone fixes the year.
// ----------------------------------------------------------------------------
module stc_date_split import stc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      time_valid,
    output logic      time_ready,
    input  stc_time_t time_data,
    stc_out_if.source date
);

    logic        v4_reg, v5_reg, v6_reg;
    logic        en4, en5, en6;

    // stage 4 registers
    logic [5:0]  s4_sec_reg;
    logic [5:0]  s4_min_reg;
    logic [4:0]  s4_hour_reg;
    logic [15:0] s4_days_reg;
    logic [5:0]  s4_quad_reg;
    logic [12:0] s4_wq_reg;
    logic [20:0] days_x24;
    logic [20:0] hour_full;
    logic [32:0] prodq;
    logic [16:0] wsum4;
    logic [34:0] prodw;

    // stage 5 registers
    logic [5:0]  s5_sec_reg;
    logic [5:0]  s5_min_reg;
    logic [4:0]  s5_hour_reg;
    logic [2:0]  s5_wday_reg;
    logic [8:0]  s5_doy_reg;
    logic [10:0] s5_year_reg;
    logic        s5_leap_reg;
    logic [15:0] quad_x1461;
    logic [15:0] rem_full;
    logic [10:0] rem;
    logic [16:0] wsum5;
    logic [16:0] wq_x7;
    logic [16:0] wday_full;
    logic [1:0]  yr_in_cycle;
    logic [10:0] doy_full;
    logic [10:0] year_next;

    // stage 6 (output) registers
    logic [5:0]  s6_sec_reg;
    logic [5:0]  s6_min_reg;
    logic [4:0]  s6_hour_reg;
    logic [4:0]  s6_mday_reg;
    logic [3:0]  s6_month_reg;
    logic [10:0] s6_year_reg;
    logic [2:0]  s6_wday_reg;
    logic [8:0]  s6_doy_reg;
    logic [3:0]  month_next;
    logic [8:0]  mday_full;

    // stage enables
    assign en6 = !v6_reg || date.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign time_ready = en4;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                v4_reg <= time_valid;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    // stage 4: hour remainder, four-year cycles, weekday quotient
    assign days_x24  = 21'(time_data.days) * 21'd24;
    assign hour_full = time_data.hours - days_x24;
    assign prodq     = 33'(time_data.days) * 33'(RECIP_1461);
    assign wsum4     = 17'(time_data.days) + 17'(WEEKDAY_BASE);
    assign prodw     = 35'(wsum4) * 35'(RECIP_7);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_sec_reg  <= time_data.second;
            s4_min_reg  <= time_data.minute;
            s4_hour_reg <= hour_full[4:0];
            s4_days_reg <= time_data.days;
            s4_quad_reg <= prodq[SHIFT_1461 +: 6];
            s4_wq_reg   <= prodw[SHIFT_7 +: 13];
        end
    end

    // stage 5: day within the cycle, year within the cycle, weekday
    assign quad_x1461 = 16'(s4_quad_reg) * DAYS_PER_4Y;
    assign rem_full   = s4_days_reg - quad_x1461;
    assign rem        = rem_full[10:0];
    assign wsum5      = 17'(s4_days_reg) + 17'(WEEKDAY_BASE);
    assign wq_x7      = 17'(s4_wq_reg) * 17'd7;
    assign wday_full  = wsum5 - wq_x7;

    always_comb
    begin
        yr_in_cycle = 2'd0;
        if (rem >= year_start(2'd1))
        begin
            yr_in_cycle = 2'd1;
        end
        if (rem >= year_start(2'd2))
        begin
            yr_in_cycle = 2'd2;
        end
        if (rem >= year_start(2'd3))
        begin
            yr_in_cycle = 2'd3;
        end
    end

    assign doy_full  = rem - year_start(yr_in_cycle);
    assign year_next = YEAR_BASE + 11'({s4_quad_reg, 2'b00}) + 11'(yr_in_cycle);

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_sec_reg  <= s4_sec_reg;
            s5_min_reg  <= s4_min_reg;
            s5_hour_reg <= s4_hour_reg;
            s5_wday_reg <= wday_full[2:0];
            s5_doy_reg  <= doy_full[8:0];
            s5_year_reg <= year_next;
            s5_leap_reg <= (yr_in_cycle == 2'd0);
        end
    end

    // stage 6: month by parallel compares against the month table
    always_comb
    begin
        month_next = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (s5_doy_reg >= month_start(s5_leap_reg, 4'(k)))
            begin
                month_next = month_next + 4'd1;
            end
        end
    end

    assign mday_full = s5_doy_reg - month_start(s5_leap_reg, month_next) + 9'd1;

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_sec_reg   <= s5_sec_reg;
            s6_min_reg   <= s5_min_reg;
            s6_hour_reg  <= s5_hour_reg;
            s6_mday_reg  <= mday_full[4:0];
            s6_month_reg <= month_next;
            s6_year_reg  <= s5_year_reg;
            s6_wday_reg  <= s5_wday_reg;
            s6_doy_reg   <= s5_doy_reg;
        end
    end

    // output channel
    assign date.valid        = v6_reg;
    assign date.second       = s6_sec_reg;
    assign date.minute       = s6_min_reg;
    assign date.hour         = s6_hour_reg;
    assign date.day_of_month = s6_mday_reg;
    assign date.month_index  = s6_month_reg;
    assign date.year         = s6_year_reg;
    assign date.weekday      = s6_wday_reg;
    assign date.day_of_year  = s6_doy_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/stc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stc_checker: port checks of the converter
// Watches the channels of the top level: output hold under stall, field
// ranges, input never blocked while the output is empty, and the latency
// of an unstalled transfer.
// ----------------------------------------------------------------------------
module stc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [5:0]  second,
    input wire [5:0]  minute,
    input wire [4:0]  hour,
    input wire [4:0]  day_of_month,
    input wire [3:0]  month_index,
    input wire [10:0] year,
    input wire [2:0]  weekday,
    input wire [8:0]  day_of_year
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(second) && $stable(minute)
        && $stable(hour) && $stable(day_of_month) && $stable(month_index)
        && $stable(year) && $stable(weekday) && $stable(day_of_year))
        else $error("result changed while stalled");

    // every result field lies in its range for the covered span
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> second < 6'd60 && minute < 6'd60 && hour < 5'd24
        && day_of_month != 5'd0 && month_index < 4'd12 && weekday < 3'd7
        && day_of_year <= 9'd365 && year >= 11'd1904 && year <= 11'd2040)
        else $error("result field out of range");

    // with the output register empty the whole pipeline can move
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // an input transfer shows up while output ready and reset stay high meanwhile
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_valid && in_ready, 6) && $past(rst_n, 6) && $past(rst_n, 5)
        && $past(rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
        && $past(out_ready, 5) && $past(out_ready, 4) && $past(out_ready, 3)
        && $past(out_ready, 2) && $past(out_ready, 1) |-> out_valid)
        else $error("result missing after six cycles");

endmodule

bind seconds_to_calendar_date_top stc_checker u_stc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (timestamp.valid),
    .in_ready     (timestamp.ready),
    .out_valid    (date.valid),
    .out_ready    (date.ready),
    .second       (date.second),
    .minute       (date.minute),
    .hour         (date.hour),
    .day_of_month (date.day_of_month),
    .month_index  (date.month_index),
    .year         (date.year),
    .weekday      (date.weekday),
    .day_of_year  (date.day_of_year)
);
`default_nettype wire
